### rtl/core/pmpm_pkg.sv
`timescale 1ns / 1ps
package pmpm_pkg;

    localparam int RES_CAP = 8;
    localparam int MAG_W   = 30;
    localparam int PROD_W  = 40;
    localparam int ACC_W   = 42;
    localparam int NUM_W   = 62;
    localparam int QUO_W   = 31;

    localparam logic [1:0] CFG_MOTOR_COUNT = 2'd0;
    localparam logic [1:0] CFG_Z_LIMIT     = 2'd1;
    localparam logic [1:0] CFG_YAW_LIMIT   = 2'd2;

    localparam logic       OP_LOAD   = 1'b0;
    localparam logic       OP_TICK   = 1'b1;
    localparam logic       AXIS_Z    = 1'b0;
    localparam logic       AXIS_YAW  = 1'b1;
    localparam logic [1:0] KIND_P    = 2'd0;
    localparam logic [1:0] KIND_I    = 2'd1;
    localparam logic [1:0] KIND_D    = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic              op;
        logic [2:0]        gain_motor;
        logic              gain_axis;
        logic [1:0]        gain_kind;
        logic signed [15:0] gain_value;
        logic signed [23:0] z_err_prop;
        logic signed [23:0] z_err_integ;
        logic signed [23:0] z_err_deriv;
        logic signed [23:0] yaw_err_prop;
        logic signed [23:0] yaw_err_integ;
        logic signed [23:0] yaw_err_deriv;
    } t_in;

    typedef struct packed {
        logic [2:0]         motor_index;
        logic signed [31:0] z_thrust;
        logic signed [31:0] yaw_thrust;
        logic signed [31:0] yaw_candidate;
        logic               z_hold_integral;
        logic               yaw_hold_integral;
        logic               last_row;
    } t_res;

    typedef struct packed {
        logic       tick;
        t_in        item;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  last_motor;
        logic [30:0] z_limit;
        logic [30:0] yaw_limit;
    } t_cfg;

endpackage

### rtl/core/per_motor_pid_mix_with_saturation_core.sv
`timescale 1ns / 1ps
// Per-motor PID mix with saturation. Load items (op 0) write one Q5.10 gain into the
// gain table; tick items (op 1) produce one result per motor in use, in motor order.
// A tick walks the gain table through one read port, taking each gain through the
// states S_RD, S_MUL and S_ACC, then, per saturated axis, scales each motor's term
// with a multiply and a bit-serial divide, then emits rows one per cycle as the consumer
// pops. Input items are queued two deep, so up to two items are accepted while a tick
// works.
module per_motor_pid_mix_with_saturation_core #(
    parameter int MAX_MOTORS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pmpm_pkg::t_in   i_in,
    output logic            o_full,
    output logic            o_empty,
    input  logic            i_pop,
    output pmpm_pkg::t_res  o_out,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data
);
    import pmpm_pkg::*;

    localparam int CAP = (MAX_MOTORS < RES_CAP) ? MAX_MOTORS : RES_CAP;

    logic [3:0]  r_motor_count;
    logic [30:0] r_z_limit, r_yaw_limit;
    logic [3:0]  eff_count;
    t_cfg        cfg;
    logic        cmd_valid, cmd_pop;
    t_cmd        cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_count <= 4'd4;
            r_z_limit     <= 31'h7FFFFFFF;
            r_yaw_limit   <= 31'h7FFFFFFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MOTOR_COUNT: r_motor_count <= i_cfg_data[3:0];
                CFG_Z_LIMIT:     r_z_limit     <= i_cfg_data[30:0];
                CFG_YAW_LIMIT:   r_yaw_limit   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (r_motor_count == 4'd0) eff_count = 4'd1;
        else if (int'(r_motor_count) > CAP)  eff_count = 4'(CAP);
        else                                 eff_count = r_motor_count;
        cfg.last_motor = 3'(eff_count - 4'd1);
        cfg.z_limit    = r_z_limit;
        cfg.yaw_limit  = r_yaw_limit;
    end

    pmpm_front #(.MAX_MOTORS(MAX_MOTORS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_in(i_in), .o_full(o_full),
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_pop(cmd_pop)
    );

    pmpm_back #(.MAX_MOTORS(MAX_MOTORS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_cmd_pop(cmd_pop), .i_cfg(cfg), .o_empty(o_empty), .o_out(o_out), .i_pop(i_pop)
    );

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk) $past(!i_rst_n) |-> o_empty)
        else $error("result present right after reset");
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_out.last_row) |-> (o_out.motor_index == cfg.last_motor))
        else $error("last row flag on wrong motor");
    a_hold_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> $stable(o_out))
        else $error("waiting result changed");
`endif
endmodule

### rtl/core/pmpm_front.sv
`timescale 1ns / 1ps
module pmpm_front #(
    parameter int MAX_MOTORS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pmpm_pkg::t_in    i_in,
    output logic             o_full,
    output logic             o_cmd_valid,
    output pmpm_pkg::t_cmd   o_cmd,
    input  logic             i_cmd_pop
);
    import pmpm_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       accept, keep;

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign accept      = i_push && !o_full;

    // Loads that address no table entry are dropped here.
    assign keep = accept && ((i_in.op == OP_TICK) ||
                  ((i_in.gain_kind != KIND_NONE) && (int'(i_in.gain_motor) < MAX_MOTORS)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (keep) begin
                r_q[r_wp] <= '{tick: (i_in.op == OP_TICK), item: i_in};
                r_wp      <= ~r_wp;
            end
            if (i_cmd_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, keep} - {1'b0, i_cmd_pop};
        end
    end
endmodule

### rtl/core/pmpm_back.sv
`timescale 1ns / 1ps
module pmpm_back #(
    parameter int MAX_MOTORS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  pmpm_pkg::t_cmd   i_cmd,
    output logic             o_cmd_pop,
    input  pmpm_pkg::t_cfg   i_cfg,
    output logic             o_empty,
    output pmpm_pkg::t_res   o_out,
    input  logic             i_pop
);
    import pmpm_pkg::*;

    localparam int DEPTH = MAX_MOTORS * 6;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RD    = 10'b0000000010,
        S_MUL   = 10'b0000000100,
        S_ACC   = 10'b0000001000,
        S_LMUL  = 10'b0000010000,
        S_LINIT = 10'b0000100000,
        S_LDIV  = 10'b0001000000,
        S_LWB   = 10'b0010000000,
        S_CAND  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state;

    logic signed [15:0] r_mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    logic signed [15:0] r_rd;
    logic               r_rd_vld;
    logic [AW-1:0]      wa, ra;
    logic               we;

    t_in                r_item;
    logic [2:0]         r_mi;
    logic               r_axis;
    logic [1:0]         r_kind;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [31:0] r_zt [RES_CAP];
    logic signed [31:0] r_yt [RES_CAP];
    logic [MAG_W-1:0]   r_zmx, r_ymx;
    logic signed [15:0] r_best;
    logic [2:0]         r_best_i;
    logic               r_found;
    logic signed [31:0] r_cand;

    logic [NUM_W-2:0]   r_nprod;
    logic [QUO_W-1:0]   r_rem, r_nlow, r_q;
    logic [4:0]         r_cnt;
    logic               r_neg;

    logic               r_out_valid;
    t_res               r_out;

    logic signed [15:0]       gain;
    logic signed [23:0]       err_sel;
    logic signed [ACC_W-1:0]  sum, rounded;
    logic signed [31:0]       term, term_sel, wb;
    logic [31:0]              term_abs, sel_abs;
    logic [MAG_W-1:0]         mag, mx_sel;
    logic [30:0]              lim_sel;
    logic                     zh, yh, hold_sel, last_m, out_go;
    logic [NUM_W-1:0]         numer;
    logic [QUO_W:0]           trial;
    logic                     ge;

    assign zh       = {1'b0, r_zmx} > i_cfg.z_limit;
    assign yh       = {1'b0, r_ymx} > i_cfg.yaw_limit;
    assign last_m   = (r_mi == i_cfg.last_motor);
    assign out_go   = (r_state == S_OUT) && (!r_out_valid || i_pop);
    assign o_empty  = !r_out_valid;
    assign o_out    = r_out;
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    // Gain table: one write port for loads, one registered read port.
    assign we = o_cmd_pop && !i_cmd.tick;
    assign wa = AW'(int'(i_cmd.item.gain_motor) * 6 + int'(i_cmd.item.gain_axis) * 3
                + int'(i_cmd.item.gain_kind));
    assign ra = AW'(int'(r_mi) * 6 + int'(r_axis) * 3 + int'(r_kind));

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= i_cmd.item.gain_value;
        r_rd <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (we) r_vld[wa] <= 1'b1;
            r_rd_vld <= r_vld[ra];
        end
    end

    always_comb begin
        gain = r_rd_vld ? r_rd : 16'sd0;
        unique case ({r_axis, r_kind})
            {AXIS_Z, KIND_P}:   err_sel = r_item.z_err_prop;
            {AXIS_Z, KIND_I}:   err_sel = r_item.z_err_integ;
            {AXIS_Z, KIND_D}:   err_sel = r_item.z_err_deriv;
            {AXIS_YAW, KIND_P}: err_sel = r_item.yaw_err_prop;
            {AXIS_YAW, KIND_I}: err_sel = r_item.yaw_err_integ;
            {AXIS_YAW, KIND_D}: err_sel = r_item.yaw_err_deriv;
            default:            err_sel = 24'sd0;
        endcase
        sum      = r_acc + ACC_W'(r_prod);
        rounded  = (sum + ACC_W'(512)) >>> 10;
        term     = rounded[31:0];
        term_abs = term[31] ? -term : term;
        mag      = term_abs[MAG_W-1:0];
        term_sel = (r_axis == AXIS_Z) ? r_zt[r_mi] : r_yt[r_mi];
        sel_abs  = term_sel[31] ? 32'(-term_sel) : 32'(term_sel);
        mx_sel   = (r_axis == AXIS_Z) ? r_zmx : r_ymx;
        lim_sel  = (r_axis == AXIS_Z) ? i_cfg.z_limit : i_cfg.yaw_limit;
        hold_sel = (r_axis == AXIS_Z) ? zh : yh;
        numer    = NUM_W'(r_nprod) + NUM_W'(mx_sel >> 1);
        trial    = {r_rem, r_nlow[QUO_W-1]};
        ge       = trial >= (QUO_W+1)'(mx_sel);
        wb       = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cand      <= 32'sd0;
            r_out_valid <= 1'b0;
            r_mi        <= '0;
            r_axis      <= AXIS_Z;
            r_kind      <= KIND_P;
        end else begin
            if (out_go) begin
                r_out_valid <= 1'b1;
                r_out <= '{motor_index: r_mi, z_thrust: r_zt[r_mi], yaw_thrust: r_yt[r_mi],
                           yaw_candidate: r_cand, z_hold_integral: zh,
                           yaw_hold_integral: yh, last_row: last_m};
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && i_cmd.tick) begin
                        r_item  <= i_cmd.item;
                        r_mi    <= '0;
                        r_axis  <= AXIS_Z;
                        r_kind  <= KIND_P;
                        r_acc   <= '0;
                        r_zmx   <= '0;
                        r_ymx   <= '0;
                        r_found <= 1'b0;
                        r_best  <= 16'sd0;
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_MUL;
                S_MUL: begin
                    r_prod <= PROD_W'(gain) * PROD_W'(err_sel);
                    if (r_axis == AXIS_YAW && r_kind == KIND_D && gain > r_best) begin
                        r_best   <= gain;
                        r_best_i <= r_mi;
                        r_found  <= 1'b1;
                    end
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_kind == KIND_D) begin
                        r_acc  <= '0;
                        r_kind <= KIND_P;
                        if (r_axis == AXIS_Z) begin
                            r_zt[r_mi] <= term;
                            if (mag > r_zmx) r_zmx <= mag;
                            r_axis  <= AXIS_YAW;
                            r_state <= S_RD;
                        end else begin
                            r_yt[r_mi] <= term;
                            if (mag > r_ymx) r_ymx <= mag;
                            r_axis <= AXIS_Z;
                            if (last_m) begin
                                r_mi    <= '0;
                                r_state <= S_LMUL;
                            end else begin
                                r_mi    <= r_mi + 3'd1;
                                r_state <= S_RD;
                            end
                        end
                    end else begin
                        r_acc   <= sum;
                        r_kind  <= r_kind + 2'd1;
                        r_state <= S_RD;
                    end
                end
                S_LMUL: begin
                    if (!hold_sel) begin
                        r_mi <= '0;
                        if (r_axis == AXIS_Z) r_axis <= AXIS_YAW;
                        else r_state <= S_CAND;
                    end else begin
                        r_neg   <= term_sel[31];
                        r_nprod <= (NUM_W-1)'(sel_abs) * (NUM_W-1)'(lim_sel);
                        r_state <= S_LINIT;
                    end
                end
                S_LINIT: begin
                    // The quotient never exceeds the limit, so it fits 31 bits.
                    r_rem   <= numer[NUM_W-1:QUO_W];
                    r_nlow  <= numer[QUO_W-1:0];
                    r_cnt   <= '0;
                    r_state <= S_LDIV;
                end
                S_LDIV: begin
                    r_rem  <= ge ? QUO_W'(trial - (QUO_W+1)'(mx_sel)) : QUO_W'(trial);
                    r_nlow <= r_nlow << 1;
                    r_q    <= {r_q[QUO_W-2:0], ge};
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'(QUO_W - 1)) r_state <= S_LWB;
                end
                S_LWB: begin
                    if (r_axis == AXIS_Z) r_zt[r_mi] <= wb;
                    else r_yt[r_mi] <= wb;
                    if (last_m) begin
                        r_mi <= '0;
                        if (r_axis == AXIS_Z) begin
                            r_axis  <= AXIS_YAW;
                            r_state <= S_LMUL;
                        end else begin
                            r_state <= S_CAND;
                        end
                    end else begin
                        r_mi    <= r_mi + 3'd1;
                        r_state <= S_LMUL;
                    end
                end
                S_CAND: begin
                    if (r_found) r_cand <= r_yt[r_best_i];
                    r_mi    <= '0;
                    r_axis  <= AXIS_Z;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_go) begin
                        if (last_m) r_state <= S_IDLE;
                        else r_mi <= r_mi + 3'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### tb/per_motor_pid_mix_with_saturation_core_tb.sv
`timescale 1ns / 1ps
module per_motor_pid_mix_with_saturation_core_tb;
    import pmpm_pkg::*;

    localparam int NUM_MOTORS  = 8;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 100;
    // Register index past the end of the register list; writes to it are ignored.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_push;
    t_in         i_in;
    logic        o_full;
    logic        o_empty;
    logic        i_pop;
    t_res        o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    per_motor_pid_mix_with_saturation_core #(.MAX_MOTORS(NUM_MOTORS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_in(i_in), .o_full(o_full),
        .o_empty(o_empty), .i_pop(i_pop), .o_out(o_out), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Mirror of the block state.
    logic signed [15:0] gains [NUM_MOTORS*6];
    longint             yaw_pick;
    logic [3:0]         motors_in_use;
    logic [30:0]        z_lim;
    logic [30:0]        yaw_lim;

    t_in  pending_items [$];
    t_res expected_rows [$];
    int   error_count;
    int   cycle_count;
    bit   no_idle;
    int   push_gap;
    int   pop_gap;

    initial begin
        i_clk = 1'b0;
    end
    always #10 i_clk = ~i_clk;

    task automatic report(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", field, got, want);
        error_count++;
    endtask

    task automatic queue_item(t_in it);
        pending_items = {pending_items, it};
    endtask

    function automatic longint mix_term(int m, int axis, longint e0, longint e1, longint e2);
        longint s;
        s = longint'(gains[m*6 + axis*3]) * e0 + longint'(gains[m*6 + axis*3 + 1]) * e1
            + longint'(gains[m*6 + axis*3 + 2]) * e2;
        return (s + 512) >>> 10;
    endfunction

    function automatic bit scale_axis(ref longint t[8], input int n, input longint limit);
        longint unsigned peak;
        longint unsigned mag;
        longint unsigned q;
        peak = 0;
        for (int i = 0; i < n; i++) begin
            mag = (t[i] < 0) ? -t[i] : t[i];
            if (mag > peak) peak = mag;
        end
        if (peak <= limit) return 1'b0;
        for (int i = 0; i < n; i++) begin
            mag = (t[i] < 0) ? -t[i] : t[i];
            q = (mag * limit + peak / 2) / peak;
            t[i] = (t[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    task automatic predict_item(t_in it);
        longint zt[8];
        longint yt[8];
        int     n;
        bit     zh;
        bit     yh;
        longint best;
        t_res   row;
        if (it.op == OP_LOAD) begin
            if (it.gain_kind != KIND_NONE)
                gains[it.gain_motor*6 + it.gain_axis*3 + it.gain_kind] = it.gain_value;
            return;
        end
        n = (motors_in_use == 0) ? 1 : (motors_in_use > NUM_MOTORS ? NUM_MOTORS : motors_in_use);
        for (int i = 0; i < n; i++) begin
            zt[i] = mix_term(i, AXIS_Z, it.z_err_prop, it.z_err_integ, it.z_err_deriv);
            yt[i] = mix_term(i, AXIS_YAW, it.yaw_err_prop, it.yaw_err_integ, it.yaw_err_deriv);
        end
        zh = scale_axis(zt, n, z_lim);
        yh = scale_axis(yt, n, yaw_lim);
        best = 0;
        for (int i = 0; i < n; i++) begin
            if (gains[i*6 + 5] > best) begin
                best = gains[i*6 + 5];
                yaw_pick = yt[i];
            end
        end
        for (int i = 0; i < n; i++) begin
            row.motor_index       = i[2:0];
            row.z_thrust          = zt[i][31:0];
            row.yaw_thrust        = yt[i][31:0];
            row.yaw_candidate     = yaw_pick[31:0];
            row.z_hold_integral   = zh;
            row.yaw_hold_integral = yh;
            row.last_row          = (i == n - 1);
            expected_rows = {expected_rows, row};
        end
    endtask

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    // Input driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push_gap = 0;
        end else begin
            if (i_push && !o_full) begin
                predict_item(i_in);
                void'(pending_items.pop_front());
                push_gap = draw_gap();
            end
            if (i_push && o_full) begin
                i_push <= 1'b1;
            end else if (push_gap > 0) begin
                push_gap = push_gap - 1;
                i_push <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_push <= 1'b1;
                i_in   <= pending_items[0];
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_pop && !o_empty) begin
                if (expected_rows.size() == 0) begin
                    report("unexpected row, motor_index", o_out.motor_index, -1);
                end else begin
                    t_res want;
                    want = expected_rows.pop_front();
                    if (o_out.motor_index !== want.motor_index)
                        report("motor_index", o_out.motor_index, want.motor_index);
                    if (o_out.z_thrust !== want.z_thrust)
                        report("z_thrust", o_out.z_thrust, want.z_thrust);
                    if (o_out.yaw_thrust !== want.yaw_thrust)
                        report("yaw_thrust", o_out.yaw_thrust, want.yaw_thrust);
                    if (o_out.yaw_candidate !== want.yaw_candidate)
                        report("yaw_candidate", o_out.yaw_candidate, want.yaw_candidate);
                    if (o_out.z_hold_integral !== want.z_hold_integral)
                        report("z_hold_integral", o_out.z_hold_integral, want.z_hold_integral);
                    if (o_out.yaw_hold_integral !== want.yaw_hold_integral)
                        report("yaw_hold_integral", o_out.yaw_hold_integral,
                               want.yaw_hold_integral);
                    if (o_out.last_row !== want.last_row)
                        report("last_row", o_out.last_row, want.last_row);
                end
                pop_gap = draw_gap();
            end
            if (pop_gap > 0) begin
                pop_gap = pop_gap - 1;
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_in load_item(int m, int axis, int kind, logic [15:0] value);
        t_in          it;
        logic [191:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = noise[$bits(t_in)-1:0];
        it.op         = OP_LOAD;
        it.gain_motor = m[2:0];
        it.gain_axis  = axis[0];
        it.gain_kind  = kind[1:0];
        it.gain_value = value;
        return it;
    endfunction

    function automatic t_in tick_item(bit full_range);
        t_in          it;
        logic [191:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = noise[$bits(t_in)-1:0];
        it.op = OP_TICK;
        if (!full_range) begin
            it.z_err_prop    = $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
            it.z_err_integ   = $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
            it.z_err_deriv   = $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
            it.yaw_err_prop  = $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
            it.yaw_err_integ = $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
            it.yaw_err_deriv = $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
        end
        return it;
    endfunction

    function automatic t_in tick_fixed(logic [23:0] e);
        t_in it;
        it = tick_item(1'b1);
        {it.z_err_prop, it.z_err_integ, it.z_err_deriv} = {e, e, e};
        {it.yaw_err_prop, it.yaw_err_integ, it.yaw_err_deriv} = {e, e, e};
        return it;
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || expected_rows.size() > 0 || i_push)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_MOTOR_COUNT: motors_in_use = data[3:0];
            CFG_Z_LIMIT:     z_lim = data[30:0];
            CFG_YAW_LIMIT:   yaw_lim = data[30:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int count);
        no_idle = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 55) begin
                queue_item(load_item($urandom_range(0, 7), $urandom_range(0, 1),
                                     $urandom_range(0, 3), 16'($urandom)));
            end else begin
                queue_item(tick_item($urandom_range(0, 1)));
            end
        end
        wait_idle();
    endtask

    initial begin
        error_count   = 0;
        cycle_count   = 0;
        no_idle       = 1'b0;
        pop_gap       = 0;
        i_rst_n       = 1'b0;
        i_push        = 1'b0;
        i_in          = '0;
        i_pop         = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_MOTOR_COUNT;
        i_cfg_data    = '0;
        foreach (gains[i]) gains[i] = '0;
        yaw_pick      = 0;
        motors_in_use = 4'd4;
        z_lim         = 31'h7FFF_FFFF;
        yaw_lim       = 31'h7FFF_FFFF;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: an empty table, extreme gains, an ignored kind and a D-gain tie.
        queue_item(tick_fixed(24'h7FFFFF));
        queue_item(load_item(0, AXIS_Z, KIND_P, 16'h7FFF));
        queue_item(load_item(0, AXIS_Z, KIND_I, 16'h7FFF));
        queue_item(load_item(0, AXIS_Z, KIND_D, 16'h7FFF));
        queue_item(load_item(1, AXIS_Z, KIND_P, 16'h8000));
        queue_item(load_item(1, AXIS_Z, KIND_I, 16'h8000));
        queue_item(load_item(1, AXIS_Z, KIND_D, 16'h8000));
        queue_item(load_item(2, AXIS_YAW, KIND_P, 16'h8000));
        queue_item(load_item(2, AXIS_YAW, KIND_D, 16'h1234));
        queue_item(load_item(3, AXIS_YAW, KIND_D, 16'h1234));
        queue_item(load_item(3, AXIS_YAW, KIND_I, 16'h7FFF));
        queue_item(load_item(3, AXIS_YAW, KIND_NONE, 16'h7FFF));
        queue_item(tick_fixed(24'h7FFFFF));
        queue_item(tick_fixed(24'h800000));
        queue_item(tick_fixed(24'h000000));
        queue_item(tick_fixed(24'h000001));
        queue_item(tick_item(1'b1));
        wait_idle();

        write_reg(CFG_MOTOR_COUNT, 32'd8);
        write_reg(CFG_Z_LIMIT, 32'd0);
        write_reg(CFG_YAW_LIMIT, 32'd0);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        queue_item(tick_fixed(24'h7FFFFF));
        queue_item(tick_fixed(24'h000000));
        queue_item(load_item(7, AXIS_YAW, KIND_D, 16'h7FFF));
        queue_item(tick_fixed(24'h800000));
        wait_idle();

        write_reg(CFG_MOTOR_COUNT, 32'd0);
        write_reg(CFG_Z_LIMIT, 32'hFFFF_FFFF);
        write_reg(CFG_YAW_LIMIT, 32'h7FFF_FFFF);
        random_phase(50);

        write_reg(CFG_MOTOR_COUNT, 32'hFFFF_FFFF);
        write_reg(CFG_Z_LIMIT, 32'($urandom_range(1, 1 << 20)));
        write_reg(CFG_YAW_LIMIT, 32'($urandom_range(1, 1 << 24)));
        random_phase(90);

        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_MOTOR_COUNT, {28'($urandom_range(0, 1 << 27)),
                                        4'($urandom_range(1, 8))});
            write_reg(CFG_Z_LIMIT, (p % 2) ? $urandom : 32'($urandom_range(0, 1 << 26)));
            write_reg(CFG_YAW_LIMIT, (p % 2) ? 32'($urandom_range(0, 1 << 22)) : $urandom);
            random_phase(48);
        end

        write_reg(CFG_MOTOR_COUNT, 32'd1);
        write_reg(CFG_Z_LIMIT, 32'd1);
        write_reg(CFG_YAW_LIMIT, 32'd1);
        random_phase(20);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/pmpm_pkg.sv
rtl/core/pmpm_front.sv
rtl/core/pmpm_back.sv
rtl/core/per_motor_pid_mix_with_saturation_core.sv
tb/per_motor_pid_mix_with_saturation_core_tb.sv
